>>> src/iefd_pkg.sv
// ---------------------------------------------------------------------------
// iefd_pkg - shared types and constants of the input event FIFO device
// Command codes, decoded work descriptor, result record and the event
// word generator used by the back end.
// ---------------------------------------------------------------------------
package iefd_pkg;

    // Stream payload widths (TDATA in whole bytes)
    localparam int S_TDATA_W = 176;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // Descriptor queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Bus map
    localparam logic [11:0] OFF_READ      = 12'h000;
    localparam logic [11:0] OFF_LEN       = 12'h004;
    localparam logic [31:0] PAGE_ABS_DATA = 32'h0002_0003;

    // Event type and code words
    localparam logic [15:0] T_SYN      = 16'h0000;
    localparam logic [15:0] T_KEY      = 16'h0001;
    localparam logic [15:0] T_REL      = 16'h0002;
    localparam logic [15:0] T_ABS      = 16'h0003;
    localparam logic [15:0] AXIS_X     = 16'h0000;
    localparam logic [15:0] AXIS_Y     = 16'h0001;
    localparam logic [15:0] AXIS_Z     = 16'h0002;
    localparam logic [15:0] CODE_TOUCH = 16'h014A;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POINTER = 2'd1,
        CMD_READ    = 2'd2,
        CMD_WRITE   = 2'd3
    } cmd_t;

    // Work kinds after classification
    typedef enum logic [2:0] {
        K_NOP   = 3'd0,
        K_PUSH  = 3'd1,
        K_TOUCH = 3'd2,
        K_TRACK = 3'd3,
        K_POP   = 3'd4,
        K_LEN   = 3'd5,
        K_PAGE  = 3'd6
    } kind_t;

    // Event and word positions inside one work item
    localparam logic [2:0] EV_0 = 3'd0;
    localparam logic [2:0] EV_1 = 3'd1;
    localparam logic [2:0] EV_2 = 3'd2;
    localparam logic [2:0] EV_3 = 3'd3;
    localparam logic [2:0] EV_4 = 3'd4;
    localparam logic [1:0] WD_TYPE  = 2'd0;
    localparam logic [1:0] WD_CODE  = 2'd1;
    localparam logic [1:0] WD_VALUE = 2'd2;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] val_a;   // raw value, X, or page write data
        logic [31:0] val_b;   // Y
        logic        btn;
    } desc_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic [2:0]  events_dropped;
        logic [9:0]  words_queued;
    } result_t;

    // Index of the last event a kind expands into
    function automatic logic [2:0] last_event(kind_t kind);
        logic [2:0] n;
        case (kind)
            K_TOUCH: n = EV_4;
            K_TRACK: n = EV_2;
            default: n = EV_0;
        endcase
        return n;
    endfunction

    // Type, code and value of one event as 32-bit ring words
    function automatic logic [31:0] event_word(desc_t d, logic [2:0] ev, logic [1:0] wd);
        logic [15:0] ty;
        logic [15:0] co;
        logic [31:0] va;
        logic [31:0] w;
        ty = T_SYN;
        co = AXIS_X;
        va = '0;
        case (d.kind)
            K_PUSH: begin
                ty = d.ev_type;
                co = d.ev_code;
                va = d.val_a;
            end
            K_TOUCH: begin
                case (ev)
                    EV_0: begin ty = T_ABS; co = AXIS_X; va = d.val_a; end
                    EV_1: begin ty = T_ABS; co = AXIS_Y; va = d.val_b; end
                    EV_2: begin ty = T_ABS; co = AXIS_Z; va = '0; end
                    EV_3: begin ty = T_KEY; co = CODE_TOUCH; va = {31'd0, d.btn}; end
                    default: begin ty = T_SYN; co = AXIS_X; va = '0; end
                endcase
            end
            K_TRACK: begin
                case (ev)
                    EV_0: begin ty = T_REL; co = AXIS_X; va = d.val_a; end
                    EV_1: begin ty = T_REL; co = AXIS_Y; va = d.val_b; end
                    default: begin ty = T_SYN; co = AXIS_X; va = '0; end
                endcase
            end
            default: begin
                ty = T_SYN;
                co = AXIS_X;
                va = '0;
            end
        endcase
        case (wd)
            WD_TYPE:  w = {16'd0, ty};
            WD_CODE:  w = {16'd0, co};
            default:  w = va;
        endcase
        return w;
    endfunction

endpackage

>>> src/input_event_fifo_device_top.sv
// Sequence: the back end takes a descriptor from the queue, dispatches it, writes
// its event words, reads the ring or updates page and phase, then registers the result.
// Throughput: one transaction per back-end sequence; the ring RAM write port
// stores one word per cycle while the engine writes event words.
// Reset: synchronous, active low; clears pointers, phase, page, IRQ and queue.
// Ring contents are undefined after reset and need no clearing pass.
// ---------------------------------------------------------------------------
// input_event_fifo_device_top - input event FIFO device
// Decode front, descriptor queue and ring execution back end with an
// interrupt line and registered result stream.
// ---------------------------------------------------------------------------
module input_event_fifo_device_top
    import iefd_pkg::*;
#(
    parameter int RING_WORDS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // ev_type[15:0], ev_code[31:16], ev_value[63:32], move_x[95:64],
    // move_y[127:96], pointer_mode[128], buttons[129], offset[141:130],
    // write_data[173:142], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data[31:0], irq_level[32], events_dropped[35:33],
    // words_queued[45:36], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_not_empty;
    desc_t   push_desc;
    desc_t   head_desc;
    result_t res;

    iefd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (push_desc)
    );

    iefd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_desc (head_desc)
    );

    iefd_back #(
        .RING_WORDS (RING_WORDS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_not_empty),
        .q_desc    (head_desc),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Result packing
    assign m_tdata = {2'b00, res.words_queued, res.events_dropped,
                      res.irq_level, res.read_data};

endmodule

>>> src/iefd_ram.sv
// ---------------------------------------------------------------------------
// iefd_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module iefd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/iefd_front.sv
// ---------------------------------------------------------------------------
// iefd_front - input transaction decode
// Unpacks the slave stream and classifies each transaction into a work
// descriptor for the back end.
// ---------------------------------------------------------------------------
module iefd_front
    import iefd_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output desc_t                q_desc
);

    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
    logic [31:0] move_x;
    logic [31:0] move_y;
    logic        pointer_mode;
    logic        buttons;
    logic [11:0] offset;
    logic [31:0] write_data;
    cmd_t        command;

    // Field unpack
    assign command      = cmd_t'(s_tuser);
    assign ev_type      = s_tdata[15:0];
    assign ev_code      = s_tdata[31:16];
    assign ev_value     = s_tdata[63:32];
    assign move_x       = s_tdata[95:64];
    assign move_y       = s_tdata[127:96];
    assign pointer_mode = s_tdata[128];
    assign buttons      = s_tdata[129];
    assign offset       = s_tdata[141:130];
    assign write_data   = s_tdata[173:142];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classification
    always_comb begin
        q_desc.ev_type = ev_type;
        q_desc.ev_code = ev_code;
        q_desc.val_b   = move_y;
        q_desc.btn     = buttons;
        q_desc.val_a   = move_x;
        q_desc.kind    = K_NOP;
        case (command)
            CMD_PUSH: begin
                q_desc.kind  = K_PUSH;
                q_desc.val_a = ev_value;
            end
            CMD_POINTER: begin
                q_desc.kind = pointer_mode ? K_TRACK : K_TOUCH;
            end
            CMD_READ: begin
                if (offset == OFF_READ) begin
                    q_desc.kind = K_POP;
                end else if (offset == OFF_LEN) begin
                    q_desc.kind = K_LEN;
                end
            end
            CMD_WRITE: begin
                q_desc.val_a = write_data;
                if (offset == OFF_READ) begin
                    q_desc.kind = K_PAGE;
                end
            end
            default: q_desc.kind = K_NOP;
        endcase
    end

endmodule

>>> src/iefd_queue.sv
// ---------------------------------------------------------------------------
// iefd_queue - descriptor queue
// Short register FIFO that decouples decode from ring execution.
// ---------------------------------------------------------------------------
module iefd_queue
    import iefd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output desc_t head_desc
);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_desc = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/iefd_back.sv
// ---------------------------------------------------------------------------
// iefd_back - ring execution engine
// Writes event words into the ring one per cycle, pops words, tracks the
// driver phase, page register and interrupt line, and holds the result.
// ---------------------------------------------------------------------------
module iefd_back
    import iefd_pkg::*;
#(
    parameter int RING_WORDS = 1024
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  desc_t   q_desc,
    output logic    q_pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int IDX_W = $clog2(RING_WORDS);
    localparam int CNT_W = $clog2(RING_WORDS + 1);
    localparam logic [CNT_W-1:0] FILL_LIMIT = CNT_W'(RING_WORDS - 4);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(RING_WORDS - 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_EVENT    = 5'b00100,
        S_READ     = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        PH_INIT     = 3'b001,
        PH_BUFFERED = 3'b010,
        PH_LIVE     = 3'b100
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    desc_t      cur_reg, cur_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [31:0] page_reg, page_next;
    logic        irq_reg, irq_next;
    logic [2:0]  ev_reg, ev_next;
    logic [1:0]  wd_reg, wd_next;
    logic [2:0]  drop_reg, drop_next;
    logic [31:0] rdata_reg, rdata_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic             ram_we;
    logic             ram_re;
    logic [31:0]      ram_wdata;
    logic [31:0]      ram_rdata;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_inc;
    logic [CNT_W-1:0] queued;
    logic [31:0]      queued_w;
    logic             ring_empty;
    logic             no_room;
    logic             ev_last;

    // Ring occupancy
    assign head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign queued     = (tail_reg >= head_reg)
                      ? CNT_W'(tail_reg) - CNT_W'(head_reg)
                      : CNT_W'(RING_WORDS) - CNT_W'(head_reg) + CNT_W'(tail_reg);
    assign queued_w   = 32'(queued);
    assign ring_empty = (head_reg == tail_reg);
    assign no_room    = (queued > FILL_LIMIT);
    assign ev_last    = (ev_reg == last_event(cur_reg.kind));
    assign ram_wdata  = event_word(cur_reg, ev_reg, wd_reg);

    iefd_ram #(
        .WIDTH (32),
        .DEPTH (RING_WORDS)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (tail_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cur_next       = cur_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        page_next      = page_reg;
        irq_next       = irq_reg;
        ev_next        = ev_reg;
        wd_next        = wd_reg;
        drop_next      = drop_reg;
        rdata_next     = rdata_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (out_valid_reg && res_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    cur_next   = q_desc;
                    q_pop      = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                rdata_next = '0;
                drop_next  = '0;
                ev_next    = EV_0;
                wd_next    = WD_TYPE;
                state_next = S_DONE;
                case (cur_reg.kind)
                    K_PUSH, K_TOUCH, K_TRACK: begin
                        state_next = S_EVENT;
                    end
                    K_POP: begin
                        if (!ring_empty) begin
                            ram_re     = 1'b1;
                            head_next  = head_inc;
                            state_next = S_READ;
                            if (head_inc == tail_reg) begin
                                irq_next = 1'b0;
                            end
                        end
                    end
                    K_LEN: begin
                        if (page_reg == PAGE_ABS_DATA) begin
                            if (phase_reg == PH_BUFFERED) begin
                                irq_next = 1'b1;
                            end
                            phase_next = PH_LIVE;
                        end
                    end
                    K_PAGE: begin
                        page_next = cur_reg.val_a;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_EVENT: begin
                if (wd_reg == WD_TYPE && no_room) begin
                    // not enough free slots: lose the whole event
                    drop_next = drop_reg + 1'b1;
                    if (ev_last) begin
                        state_next = S_DONE;
                    end else begin
                        ev_next = ev_reg + 1'b1;
                    end
                end else begin
                    if (wd_reg == WD_TYPE && ring_empty) begin
                        if (phase_reg == PH_LIVE) begin
                            irq_next = 1'b1;
                        end else begin
                            phase_next = PH_BUFFERED;
                        end
                    end
                    ram_we    = 1'b1;
                    tail_next = tail_inc;
                    if (wd_reg == WD_VALUE) begin
                        wd_next = WD_TYPE;
                        if (ev_last) begin
                            state_next = S_DONE;
                        end else begin
                            ev_next = ev_reg + 1'b1;
                        end
                    end else begin
                        wd_next = wd_reg + 1'b1;
                    end
                end
            end
            S_READ: begin
                rdata_next = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || res_ready) begin
                    out_next.read_data      = rdata_reg;
                    out_next.irq_level      = irq_reg;
                    out_next.events_dropped = drop_reg;
                    out_next.words_queued   = queued_w[9:0];
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_INIT;
            head_reg      <= '0;
            tail_reg      <= '0;
            page_reg      <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            page_reg      <= page_next;
            irq_reg       <= irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        ev_reg    <= ev_next;
        wd_reg    <= wd_next;
        drop_reg  <= drop_next;
        rdata_reg <= rdata_next;
        out_reg   <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> tb/input_event_fifo_device_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// input_event_fifo_device_checker - result checker for the event FIFO device
// Watches both stream channels, keeps its own copy of the ring, pointers,
// driver phase, page register and IRQ line, predicts one result record per
// accepted input transaction and compares every output transaction with the
// oldest prediction, field by field.
// ---------------------------------------------------------------------------
module input_event_fifo_device_checker
    import iefd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   outstanding,
    output int                   ring_level
);

    localparam int RING_WORDS = 1024;
    localparam int RING_SPACE = RING_WORDS - 1;   // one slot always kept free
    localparam int PRINT_CAP  = 60;

    typedef enum logic [1:0] {
        PH_INIT     = 2'd0,
        PH_BUFFERED = 2'd1,
        PH_LIVE     = 2'd2
    } drv_phase_t;

    // Shadow of the device state
    logic [31:0] ring_mem [RING_WORDS];
    logic [9:0]  rd_ptr;
    logic [9:0]  wr_ptr;
    drv_phase_t  phase;
    logic [31:0] page_reg;
    logic        irq_reg;

    result_t     expected_q [$];
    int          fault_count   = 0;
    int          pending_count = 0;
    int          level_hint    = 0;

    assign mismatches  = fault_count;
    assign outstanding = pending_count;
    assign ring_level  = level_hint;

    function automatic logic [9:0] fill_level();
        return wr_ptr - rd_ptr;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fault_count < PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        fault_count++;
    endtask

    // Store one three-word event, or count it as lost when the ring is full
    task automatic store_event(input logic [31:0] ty, input logic [31:0] co,
                               input logic [31:0] va, inout logic [2:0] lost);
        if (int'(fill_level()) + 3 > RING_SPACE) begin
            lost = lost + 3'd1;
        end else begin
            if (rd_ptr == wr_ptr) begin
                if (phase == PH_LIVE)
                    irq_reg = 1'b1;
                else
                    phase = PH_BUFFERED;
            end
            ring_mem[wr_ptr] = ty;
            wr_ptr = wr_ptr + 10'd1;
            ring_mem[wr_ptr] = co;
            wr_ptr = wr_ptr + 10'd1;
            ring_mem[wr_ptr] = va;
            wr_ptr = wr_ptr + 10'd1;
        end
    endtask

    // Pop the oldest word; an empty ring reads as zero
    task automatic take_word(output logic [31:0] w);
        w = '0;
        if (rd_ptr != wr_ptr) begin
            w = ring_mem[rd_ptr];
            rd_ptr = rd_ptr + 10'd1;
            if (rd_ptr == wr_ptr)
                irq_reg = 1'b0;
        end
    endtask

    // Apply one input transaction to the shadow state and form its result
    task automatic predict_result(input cmd_t cmd, input logic [S_TDATA_W-1:0] d,
                                  output result_t r);
        logic [15:0] ety;
        logic [15:0] eco;
        logic [31:0] eva;
        logic [31:0] mx;
        logic [31:0] my;
        logic        mode;
        logic        btn;
        logic [11:0] off;
        logic [31:0] wdat;
        logic [31:0] rdata;
        logic [2:0]  lost;
        ety   = d[15:0];
        eco   = d[31:16];
        eva   = d[63:32];
        mx    = d[95:64];
        my    = d[127:96];
        mode  = d[128];
        btn   = d[129];
        off   = d[141:130];
        wdat  = d[173:142];
        rdata = '0;
        lost  = '0;
        case (cmd)
            CMD_PUSH: begin
                store_event({16'd0, ety}, {16'd0, eco}, eva, lost);
            end
            CMD_POINTER: begin
                if (!mode) begin
                    store_event({16'd0, T_ABS}, {16'd0, AXIS_X}, mx, lost);
                    store_event({16'd0, T_ABS}, {16'd0, AXIS_Y}, my, lost);
                    store_event({16'd0, T_ABS}, {16'd0, AXIS_Z}, 32'd0, lost);
                    store_event({16'd0, T_KEY}, {16'd0, CODE_TOUCH}, {31'd0, btn}, lost);
                end else begin
                    store_event({16'd0, T_REL}, {16'd0, AXIS_X}, mx, lost);
                    store_event({16'd0, T_REL}, {16'd0, AXIS_Y}, my, lost);
                end
                store_event({16'd0, T_SYN}, {16'd0, AXIS_X}, 32'd0, lost);
            end
            CMD_READ: begin
                // length read on the absolute-data page hands over to the driver
                if (off == OFF_LEN && page_reg == PAGE_ABS_DATA) begin
                    if (phase == PH_BUFFERED)
                        irq_reg = 1'b1;
                    phase = PH_LIVE;
                end
                if (off == OFF_READ)
                    take_word(rdata);
            end
            default: begin
                if (off == OFF_READ)
                    page_reg = wdat;
            end
        endcase
        r.read_data      = rdata;
        r.irq_level      = irq_reg;
        r.events_dropped = lost;
        r.words_queued   = fill_level();
    endtask

    // Channel monitor: predict on input transactions, compare on output ones
    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            rd_ptr   = '0;
            wr_ptr   = '0;
            phase    = PH_INIT;
            page_reg = '0;
            irq_reg  = 1'b0;
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_result(cmd_t'(s_tuser[1:0]), s_tdata, want);
                expected_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[31:0] !== want.read_data)
                        report_mismatch("read_data", m_tdata[31:0], want.read_data);
                    if (m_tdata[32] !== want.irq_level)
                        report_mismatch("irq_level", {31'd0, m_tdata[32]},
                                        {31'd0, want.irq_level});
                    if (m_tdata[35:33] !== want.events_dropped)
                        report_mismatch("events_dropped", {29'd0, m_tdata[35:33]},
                                        {29'd0, want.events_dropped});
                    if (m_tdata[45:36] !== want.words_queued)
                        report_mismatch("words_queued", {22'd0, m_tdata[45:36]},
                                        {22'd0, want.words_queued});
                end
            end
        end
        pending_count <= expected_q.size();
        level_hint    <= int'(fill_level());
    end

endmodule

>>> tb/input_event_fifo_device_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// input_event_fifo_device_top_tb - stimulus and verdict for the event FIFO
// Drives a directed opening (empty reads, driver handover, field extremes,
// every command) and then random bursts of fills, drains, mixed traffic and
// noise under varying sender gaps and receiver stalls. Checking is done by
// the checker instance; this module only turns its final count into a verdict.
// ---------------------------------------------------------------------------
module input_event_fifo_device_top_tb;
    import iefd_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_LIMIT  = 40000;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_POPS     = 1100;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int ring_level;
    int sent_count = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;

    input_event_fifo_device_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    input_event_fifo_device_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .ring_level  (ring_level)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Safety net
    initial begin
        #10_000_000;
        $display("input_event_fifo_device_top verification failed");
        $finish;
    end

    function automatic logic [S_TDATA_W-1:0] make_payload(
        input logic [15:0] ty, input logic [15:0] co, input logic [31:0] va,
        input logic [31:0] mx, input logic [31:0] my, input logic mode,
        input logic btn, input logic [11:0] off, input logic [31:0] wd);
        return {{(S_TDATA_W - 174){1'b0}}, wd, off, btn, mode, my, mx, va, co, ty};
    endfunction

    // 32-bit value biased towards the signed and unsigned extremes
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(7))
            0:       w = 32'h8000_0000;
            1:       w = 32'h7FFF_FFFF;
            2:       w = 32'h0000_0000;
            3:       w = 32'hFFFF_FFFF;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Read offset, mostly other than pop: length, data area or anywhere
    function automatic logic [11:0] pick_offset();
        logic [11:0] off;
        case ($urandom_range(3))
            0:       off = OFF_LEN;
            1:       off = 12'h008 + 12'($urandom_range(15)) * 12'd4;
            default: off = 12'($urandom_range(4095));
        endcase
        return off;
    endfunction

    // One input transaction; gap and stall rates follow the idling phase
    task automatic send_item(input cmd_t cmd, input logic [S_TDATA_W-1:0] payload);
        case ((sent_count / 90) % 5)
            1:       begin idle_pct = 61; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 61; end
            3:       begin idle_pct = 25; stall_pct = 25; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic push_raw(input logic [15:0] ty, input logic [15:0] co,
                            input logic [31:0] va);
        send_item(CMD_PUSH, make_payload(ty, co, va, $urandom, $urandom,
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  12'($urandom_range(4095)), $urandom));
    endtask

    task automatic report_pointer(input logic mode, input logic [31:0] x,
                                  input logic [31:0] y, input logic btn);
        send_item(CMD_POINTER, make_payload(16'($urandom), 16'($urandom), $urandom,
                  x, y, mode, btn, 12'($urandom_range(4095)), $urandom));
    endtask

    task automatic bus_read(input logic [11:0] off);
        send_item(CMD_READ, make_payload(16'($urandom), 16'($urandom), $urandom,
                  $urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  off, $urandom));
    endtask

    task automatic bus_write(input logic [11:0] off, input logic [31:0] data);
        send_item(CMD_WRITE, make_payload(16'($urandom), 16'($urandom), $urandom,
                  $urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  off, data));
    endtask

    // Hold the sender until every predicted result has been received
    task automatic wait_for_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // Pop words until the ring is empty or the pop budget is spent, then a
    // read or two more
    task automatic drain_ring(input int limit);
        int pops;
        pops = 0;
        while (ring_level != 0 && pops < limit) begin
            bus_read(OFF_READ);
            pops++;
        end
        repeat ($urandom_range(1, 2)) bus_read(OFF_READ);
    endtask

    task automatic random_pointer();
        report_pointer(1'($urandom_range(1)), pick_word(), pick_word(),
                       1'($urandom_range(1)));
    endtask

    // Mixed traffic, pops outweighing pushes per transaction
    task automatic mixed_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            push_raw(16'($urandom), 16'($urandom), pick_word());
        else if (pick < 32)
            random_pointer();
        else if (pick < 85)
            bus_read(OFF_READ);
        else if (pick < 90)
            bus_read(OFF_LEN);
        else if (pick < 94)
            bus_read(pick_offset());
        else if (pick < 97)
            bus_write(OFF_READ, $urandom_range(1) ? PAGE_ABS_DATA : pick_word());
        else
            bus_write(12'($urandom_range(4095)), pick_word());
    endtask

    // Stimulus
    initial begin : stimulus
        int start_count;
        int pick;
        int n;
        bit paused;
        paused = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pops, handover with an empty ring, field extremes
        bus_read(OFF_READ);
        bus_read(OFF_LEN);
        bus_write(12'hFFF, 32'hFFFF_FFFF);
        push_raw(16'hFFFF, 16'hFFFF, 32'h8000_0000);
        bus_write(OFF_READ, PAGE_ABS_DATA);
        repeat (3) bus_read(OFF_READ);
        bus_read(OFF_READ);
        bus_read(OFF_LEN);
        bus_read(12'h008);
        bus_read(12'hFFF);
        push_raw(16'h0000, 16'h0000, 32'h7FFF_FFFF);
        report_pointer(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        report_pointer(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        report_pointer(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        report_pointer(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        bus_write(OFF_READ, 32'hFFFF_FFFF);
        bus_read(OFF_LEN);
        bus_write(OFF_READ, PAGE_ABS_DATA);
        bus_read(OFF_LEN);
        drain_ring(MAX_POPS);
        push_raw(16'($urandom), 16'($urandom), 32'h8000_0000);
        wait_for_results();

        // Random bursts
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                n = $urandom_range(10, 40);
                repeat (n) mixed_item();
            end else if (pick < 65) begin
                // fill: mostly pointer reports, enough to overrun the ring
                n = $urandom_range(20, 80);
                repeat (n) begin
                    if ($urandom_range(9) == 0)
                        push_raw(16'($urandom), 16'($urandom), pick_word());
                    else
                        random_pointer();
                end
            end else if (pick < 85) begin
                drain_ring(RANDOM_ITEMS - (sent_count - start_count));
            end else begin
                // noise: any command, any field values
                n = $urandom_range(5, 15);
                repeat (n)
                    send_item(cmd_t'($urandom_range(3)),
                              make_payload(16'($urandom), 16'($urandom), $urandom,
                                           $urandom, $urandom, 1'($urandom_range(1)),
                                           1'($urandom_range(1)),
                                           12'($urandom_range(4095)), $urandom));
            end
            if (!paused && sent_count - start_count >= RANDOM_ITEMS / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end

        // Closing
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("input_event_fifo_device_top verification clean");
        else
            $display("input_event_fifo_device_top verification failed");
        $finish;
    end

endmodule
